/* hw/rtl/sbwd_pkg.sv */
// shared types and constants for the scope block waveform deframer
package sbwd_pkg;

  localparam int MAX_CHANNELS      = 4;
  localparam int SAMPLE_COUNT_BITS = 24;
  localparam int CHAN_BITS         = 3;
  localparam int CHAN_IDX_BITS     = 2;
  localparam int EVENT_BITS        = 32;
  localparam int CFG_INDEX_BITS    = 2;
  localparam int CFG_DATA_BITS     = 32;
  localparam int TDATA_BITS        = 72;
  localparam int TUSER_BITS        = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLES_PER_CHANNEL = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT       = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EVENT_LIMIT         = 2'd2;

  localparam logic [SAMPLE_COUNT_BITS-1:0] SAMPLES_RESET = 24'd1000;
  localparam logic [CHAN_BITS-1:0]         CHANNELS_RESET = 3'd1;
  localparam logic [EVENT_BITS-1:0]        LIMIT_RESET   = 32'd1;

  localparam logic [7:0] CHAR_HASH    = 8'h23;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;

  localparam logic [3:0] DIGITS_MAX = 4'd15;

  typedef enum logic [1:0] {
    PHASE_HEADER  = 2'd0,
    PHASE_SAMPLES = 2'd1,
    PHASE_TRAILER = 2'd2
  } phase_t;

  typedef enum logic {
    KIND_SAMPLE    = 1'b0,
    KIND_EVENT_END = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                        item_kind;
    logic [7:0]                   sample_value;
    logic [CHAN_IDX_BITS-1:0]     channel_index;
    logic [SAMPLE_COUNT_BITS-1:0] sample_index;
    logic [EVENT_BITS-1:0]        event_number;
    logic                         limit_reached;
  } result_t;

  typedef struct packed {
    logic [SAMPLE_COUNT_BITS-1:0] samples_per_channel;
    logic [CHAN_BITS-1:0]         channel_count;
    logic [EVENT_BITS-1:0]        event_limit;
  } cfg_t;

endpackage

/* hw/rtl/sbwd_parser.sv */
// parse state and per-byte result logic of the deframer
module sbwd_parser
  import sbwd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       accept,
  input  logic [7:0] data_byte,
  output logic       res_valid,
  output result_t    res
);

  phase_t                       phase, phase_next;
  logic                         await_count, await_count_next;
  logic [3:0]                   digit_count, digit_count_next;
  logic [3:0]                   digits_seen, digits_seen_next;
  logic [CHAN_BITS-1:0]         cur_chan, cur_chan_next;
  logic [SAMPLE_COUNT_BITS-1:0] sample_cnt, sample_cnt_next;
  logic [EVENT_BITS-1:0]        events_done, events_done_next;
  logic                         stopped, stopped_next;

  logic [CHAN_BITS-1:0]         eff_chans;
  logic [SAMPLE_COUNT_BITS-1:0] sample_inc;
  logic [CHAN_BITS-1:0]         chan_inc;
  logic [EVENT_BITS-1:0]        events_inc;
  logic                         limit_hit;
  logic [3:0]                   seen_inc;
  logic                         is_digit;

  always_comb begin
    if (cfg.channel_count == '0) begin
      eff_chans = CHAN_BITS'(1);
    end else if (cfg.channel_count > CHAN_BITS'(MAX_CHANNELS)) begin
      eff_chans = CHAN_BITS'(MAX_CHANNELS);
    end else begin
      eff_chans = cfg.channel_count;
    end
  end

  assign sample_inc = sample_cnt + 1'b1;
  assign chan_inc   = cur_chan + 1'b1;
  assign events_inc = events_done + 1'b1;
  assign limit_hit  = events_inc >= cfg.event_limit;
  assign seen_inc   = (digits_seen < DIGITS_MAX) ? digits_seen + 1'b1 : digits_seen;
  assign is_digit   = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);

  // next state
  always_comb begin
    phase_next       = phase;
    await_count_next = await_count;
    digit_count_next = digit_count;
    digits_seen_next = digits_seen;
    cur_chan_next    = cur_chan;
    sample_cnt_next  = sample_cnt;
    events_done_next = events_done;
    stopped_next     = stopped;
    if (!stopped) begin
      unique case (phase)
        PHASE_SAMPLES: begin
          sample_cnt_next = sample_inc;
          if (sample_inc == cfg.samples_per_channel) begin
            sample_cnt_next = '0;
            cur_chan_next   = chan_inc;
            phase_next      = (chan_inc >= eff_chans) ? PHASE_TRAILER : PHASE_HEADER;
          end
        end
        PHASE_TRAILER: begin
          if (data_byte == CHAR_NEWLINE) begin
            events_done_next = events_inc;
            if (limit_hit) begin
              stopped_next = 1'b1;
            end else begin
              phase_next      = PHASE_HEADER;
              cur_chan_next   = '0;
              sample_cnt_next = '0;
            end
          end
        end
        default: begin
          if (data_byte == CHAR_HASH) begin
            await_count_next = 1'b1;
          end else if (await_count) begin
            digit_count_next = is_digit ? 4'(data_byte - CHAR_ZERO) : 4'd0;
            digits_seen_next = '0;
            await_count_next = 1'b0;
          end else begin
            digits_seen_next = seen_inc;
            if (seen_inc >= digit_count) begin
              phase_next = PHASE_SAMPLES;
            end
          end
        end
      endcase
    end
  end

  // result
  always_comb begin
    res_valid         = 1'b0;
    res.item_kind     = KIND_SAMPLE;
    res.sample_value  = '0;
    res.channel_index = '0;
    res.sample_index  = '0;
    res.event_number  = events_done;
    res.limit_reached = 1'b0;
    if (!stopped) begin
      unique case (phase)
        PHASE_SAMPLES: begin
          res_valid         = 1'b1;
          res.sample_value  = data_byte;
          res.channel_index = cur_chan[CHAN_IDX_BITS-1:0];
          res.sample_index  = sample_cnt;
        end
        PHASE_TRAILER: begin
          res_valid         = (data_byte == CHAR_NEWLINE);
          res.item_kind     = KIND_EVENT_END;
          res.limit_reached = limit_hit;
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PHASE_HEADER;
      await_count <= 1'b0;
      digit_count <= '0;
      digits_seen <= '0;
      cur_chan    <= '0;
      sample_cnt  <= '0;
      events_done <= '0;
      stopped     <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      await_count <= await_count_next;
      digit_count <= digit_count_next;
      digits_seen <= digits_seen_next;
      cur_chan    <= cur_chan_next;
      sample_cnt  <= sample_cnt_next;
      events_done <= events_done_next;
      stopped     <= stopped_next;
    end
  end

endmodule

/* hw/rtl/scope_block_waveform_deframer.sv */
// top level of the scope block waveform deframer
//
// usage:
// - s_* takes the raw reply stream, one byte per request in s_tdata[7:0]
// - each event is channel_count blocks of '#', a digit count, length digits
//   and samples_per_channel sample bytes, then trailer bytes up to newline
// - m_* gives one request per sample byte and one per end of event
// - cfg_we/cfg_index/cfg_data write samples_per_channel (0), channel_count (1),
//   event_limit (2); only while the block is idle, a rule the user must keep
// - header and trailer bytes other than newline give no output request
// - a result is registered in the result queue when its byte is taken
// - throughput: one byte per cycle while the queue has room; the combinational
//   parse step lies between the input handshake and the two-entry result queue
// - s_tready is low only while both queue entries hold results; a stalled
//   receiver lets results fill both entries before the input stalls
// - after event_limit events all input bytes are taken and dropped
// - rst clears the parse state, the event count and the queue, and loads
//   the register defaults
module scope_block_waveform_deframer
  import sbwd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,   // data_byte
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // sample_value, channel_index, sample_index, event_number, zero pad
  output logic [TDATA_BITS-1:0]     m_tdata,
  output logic [TUSER_BITS-1:0]     m_tuser    // item_kind, limit_reached
);

  cfg_t    cfg;
  logic    accept;
  logic    res_valid;
  result_t res;
  result_t q0, q1;
  logic [1:0] q_count;
  logic    push, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.samples_per_channel <= SAMPLES_RESET;
      cfg.channel_count       <= CHANNELS_RESET;
      cfg.event_limit         <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLES_PER_CHANNEL: cfg.samples_per_channel <= cfg_data[SAMPLE_COUNT_BITS-1:0];
        REG_CHANNEL_COUNT:       cfg.channel_count       <= cfg_data[CHAN_BITS-1:0];
        REG_EVENT_LIMIT:         cfg.event_limit         <= cfg_data[EVENT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready = (q_count != 2'd2);
  assign accept   = s_tvalid && s_tready;

  sbwd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .data_byte (s_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  assign push = accept && res_valid;
  assign pop  = m_tvalid && m_tready;

  // two-entry result queue, head in q0
  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= '0;
    end else begin
      if (push && !pop) begin
        q_count <= q_count + 1'b1;
      end else if (pop && !push) begin
        q_count <= q_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (q_count == 2'd1) begin
        q0 <= res;
      end else begin
        q0 <= q1;
        q1 <= res;
      end
    end else if (pop) begin
      q0 <= q1;
    end else if (push) begin
      if (q_count == 2'd0) begin
        q0 <= res;
      end else begin
        q1 <= res;
      end
    end
  end

  assign m_tvalid = (q_count != 2'd0);
  assign m_tdata  = {6'd0, q0.event_number, q0.sample_index, q0.channel_index,
                     q0.sample_value};
  assign m_tuser  = {q0.limit_reached, q0.item_kind};

endmodule

/* tb/scope_block_waveform_deframer_checker.sv */
`timescale 1ns / 1ps
// checker for the deframer: predicts each output request from the byte stream and compares
module scope_block_waveform_deframer_checker
  import sbwd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [7:0]                s_tdata,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [TDATA_BITS-1:0]     m_tdata,
  input  logic [TUSER_BITS-1:0]     m_tuser,
  output int                        fail_count,
  output int                        pending,
  output logic                      sample_run_open
);

  logic [SAMPLE_COUNT_BITS-1:0] samples_per_block;
  logic [CHAN_BITS-1:0]         channels_cfg;
  logic [EVENT_BITS-1:0]        limit_cfg;

  phase_t                       phase;
  logic                         armed;
  logic [3:0]                   digit_count;
  logic [3:0]                   digits_seen;
  logic [CHAN_BITS-1:0]         channel;
  logic [SAMPLE_COUNT_BITS-1:0] sample_count;
  logic [EVENT_BITS-1:0]        events_done;
  logic                         halted;

  result_t predicted_items[$];

  assign sample_run_open = (phase == PHASE_SAMPLES);

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [SAMPLE_COUNT_BITS-1:0] next_count;
    logic [CHAN_BITS-1:0]         eff;
    logic                         lim;
    result_t                      r;
    eff = (channels_cfg == 0) ? CHAN_BITS'(1) :
          (channels_cfg > MAX_CHANNELS) ? CHAN_BITS'(MAX_CHANNELS) : channels_cfg;
    r = '0;
    if (halted) return;
    case (phase)
      PHASE_SAMPLES: begin
        next_count = sample_count + 1'b1;
        r.item_kind = KIND_SAMPLE;
        r.sample_value = b;
        r.channel_index = channel[CHAN_IDX_BITS-1:0];
        r.sample_index = sample_count;
        r.event_number = events_done;
        r.limit_reached = 1'b0;
        predicted_items.push_back(r);
        sample_count = next_count;
        if (next_count == samples_per_block) begin
          sample_count = '0;
          channel = channel + 1'b1;
          phase = (channel >= eff) ? PHASE_TRAILER : PHASE_HEADER;
        end
      end
      PHASE_TRAILER: begin
        if (b == CHAR_NEWLINE) begin
          events_done = events_done + 1'b1;
          lim = (events_done >= limit_cfg);
          r.item_kind = KIND_EVENT_END;
          r.event_number = events_done - 1'b1;
          r.limit_reached = lim;
          predicted_items.push_back(r);
          if (lim) begin
            halted = 1'b1;
          end else begin
            phase = PHASE_HEADER;
            channel = '0;
            sample_count = '0;
          end
        end
      end
      default: begin
        if (b == CHAR_HASH) begin
          armed = 1'b1;
        end else if (armed) begin
          digit_count = (b >= CHAR_ZERO && b <= CHAR_NINE) ? 4'(b - CHAR_ZERO) : 4'd0;
          digits_seen = '0;
          armed = 1'b0;
        end else begin
          if (digits_seen < DIGITS_MAX) digits_seen = digits_seen + 1'b1;
          if (digits_seen >= digit_count) phase = PHASE_SAMPLES;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      samples_per_block = SAMPLES_RESET;
      channels_cfg = CHANNELS_RESET;
      limit_cfg = LIMIT_RESET;
      phase = PHASE_HEADER;
      armed = 1'b0;
      digit_count = '0;
      digits_seen = '0;
      channel = '0;
      sample_count = '0;
      events_done = '0;
      halted = 1'b0;
      predicted_items.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.item_kind = kind_t'(m_tuser[0]);
        got.limit_reached = m_tuser[1];
        got.sample_value = m_tdata[7:0];
        got.channel_index = m_tdata[9:8];
        got.sample_index = m_tdata[33:10];
        got.event_number = m_tdata[65:34];
        if (predicted_items.size() == 0) begin
          fail_count++;
          $error("output request with no prediction waiting");
        end else begin
          want = predicted_items.pop_front();
          check_field("item_kind", 32'(want.item_kind), 32'(got.item_kind));
          check_field("sample_value", 32'(want.sample_value), 32'(got.sample_value));
          check_field("channel_index", 32'(want.channel_index), 32'(got.channel_index));
          check_field("sample_index", 32'(want.sample_index), 32'(got.sample_index));
          check_field("event_number", want.event_number, got.event_number);
          check_field("limit_reached", 32'(want.limit_reached), 32'(got.limit_reached));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SAMPLES_PER_CHANNEL: samples_per_block = cfg_data[SAMPLE_COUNT_BITS-1:0];
          REG_CHANNEL_COUNT:       channels_cfg = cfg_data[CHAN_BITS-1:0];
          REG_EVENT_LIMIT:         limit_cfg = cfg_data[EVENT_BITS-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) parse_byte(s_tdata);
    end
    pending = predicted_items.size();
  end

endmodule

/* tb/scope_block_waveform_deframer_test.sv */
`timescale 1ns / 1ps
// top of the deframer testbench: clock, reset, byte stream stimulus and verdict
module scope_block_waveform_deframer_test;
  import sbwd_pkg::*;

  localparam logic [7:0] CHAR_SEMICOLON = 8'h3b;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [7:0]                s_tdata = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [TDATA_BITS-1:0]     m_tdata;
  logic [TUSER_BITS-1:0]     m_tuser;

  int   fail_count;
  int   pending;
  logic sample_run_open;

  int send_idle = 0;
  int recv_stall = 0;
  int bytes_sent = 0;
  logic [CHAN_BITS-1:0]         channels_now = CHANNELS_RESET;
  logic [SAMPLE_COUNT_BITS-1:0] samples_now = SAMPLES_RESET;

  scope_block_waveform_deframer i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  scope_block_waveform_deframer_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .fail_count     (fail_count),
    .pending        (pending),
    .sample_run_open(sample_run_open)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // finishes any open sample block first so a shorter block size cannot strand it
  task automatic set_format(input logic [CHAN_BITS-1:0] ch,
                            input logic [SAMPLE_COUNT_BITS-1:0] spc,
                            input logic [EVENT_BITS-1:0] limit);
    drain();
    while (sample_run_open) begin
      send_byte(8'($urandom_range(255)));
      drain();
    end
    write_reg(REG_CHANNEL_COUNT, CFG_DATA_BITS'(ch));
    write_reg(REG_SAMPLES_PER_CHANNEL, CFG_DATA_BITS'(spc));
    write_reg(REG_EVENT_LIMIT, limit);
    channels_now = ch;
    samples_now = spc;
  endtask

  task automatic send_event();
    int chans;
    int d;
    logic [7:0] b;
    chans = (channels_now == 0) ? 1 :
            (channels_now > MAX_CHANNELS) ? MAX_CHANNELS : int'(channels_now);
    for (int c = 0; c < chans; c++) begin
      send_byte(CHAR_HASH);
      d = $urandom_range(9);
      send_byte(CHAR_ZERO + 8'(d));
      for (int i = 0; i < ((d == 0) ? 1 : d); i++) send_byte(CHAR_ZERO + 8'($urandom_range(9)));
      for (int i = 0; i < int'(samples_now); i++) send_byte(8'($urandom_range(255)));
    end
    if ($urandom_range(1)) send_byte(CHAR_SEMICOLON);
    repeat ($urandom_range(3)) begin
      b = 8'($urandom_range(255));
      send_byte((b == CHAR_NEWLINE) ? CHAR_SEMICOLON : b);
    end
    send_byte(CHAR_NEWLINE);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 20)) begin
      case ($urandom_range(3))
        0:       send_byte(CHAR_HASH);
        1:       send_byte(CHAR_NEWLINE);
        2:       send_byte(CHAR_ZERO + 8'($urandom_range(9)));
        default: send_byte(8'($urandom_range(255)));
      endcase
    end
  endtask

  initial begin
    int goal;
    int k;
    logic [CHAN_BITS-1:0]         ch;
    logic [SAMPLE_COUNT_BITS-1:0] spc;
    logic [EVENT_BITS-1:0]        limit;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed event: largest and zero block sizes, hash inside a header,
    // non-digit count, trailer bytes
    send_idle = 16;
    recv_stall = 16;
    write_reg(REG_EVENT_LIMIT, '1);
    write_reg(REG_CHANNEL_COUNT, 2);
    write_reg(REG_SAMPLES_PER_CHANNEL, 32'hffffff);
    channels_now = 3'd2;
    send_byte(CHAR_HASH);
    send_byte("0");
    send_byte("5");
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h5a);
    drain();
    write_reg(REG_SAMPLES_PER_CHANNEL, 4);
    send_byte(8'ha5);
    send_byte(CHAR_HASH);
    send_byte("3");
    send_byte("1");
    send_byte(CHAR_HASH);
    send_byte("x");
    send_byte("7");
    drain();
    write_reg(REG_SAMPLES_PER_CHANNEL, 0);
    send_byte(CHAR_NEWLINE);
    send_byte(CHAR_HASH);
    drain();
    write_reg(REG_SAMPLES_PER_CHANNEL, 3);
    send_byte(CHAR_SEMICOLON);
    send_byte(CHAR_SEMICOLON);
    send_byte("A");
    send_byte(CHAR_NEWLINE);
    samples_now = 24'd3;

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin send_idle = 0;  recv_stall = 0;  end
        1:       begin send_idle = 87; recv_stall = 0;  end
        2:       begin send_idle = 0;  recv_stall = 87; end
        default: begin send_idle = 16; recv_stall = 16; end
      endcase
      goal = bytes_sent + 490;
      k = 0;
      while (bytes_sent < goal) begin
        if (k % 4 == 0) begin
          if (k == 0) begin
            case (p)
              0:       ch = 3'd4;
              1:       ch = 3'd0;
              2:       ch = 3'd7;
              default: ch = 3'd1;
            endcase
          end else begin
            ch = 3'($urandom_range(7));
          end
          spc = ($urandom_range(9) == 0) ? 24'($urandom_range(7, 40)) :
                                           24'($urandom_range(1, 6));
          limit = (p == 0 && k == 0) ? '1 : {1'b1, 31'($urandom())};
          set_format(ch, spc, limit);
        end
        if ($urandom_range(99) < 15) send_noise();
        else send_event();
        k++;
      end
    end

    // lowered limit: the next event end stops the block, later bytes are dropped
    set_format(3'($urandom_range(1, 4)), 24'($urandom_range(1, 4)),
               EVENT_BITS'($urandom_range(1)));
    send_event();
    send_event();
    send_noise();
    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("scope_block_waveform_deframer regression: pass");
    end else begin
      $display("scope_block_waveform_deframer regression: fail");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("scope_block_waveform_deframer regression: fail");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/sbwd_pkg.sv
hw/rtl/sbwd_parser.sv
hw/rtl/scope_block_waveform_deframer.sv
tb/scope_block_waveform_deframer_checker.sv
tb/scope_block_waveform_deframer_test.sv
